>>> rtl/pimrc_pkg.sv
// ----------------------------------------------------------------------------
// pimrc_pkg
// Shared widths, limits, types and controller states of the per-id message
// rate counter.
// ----------------------------------------------------------------------------
`default_nettype none

package pimrc_pkg;

	localparam int ID_W           = 32;
	localparam int TICK_W         = 6;
	localparam int COUNT_W        = 16;
	localparam int TOTAL_W        = 21;
	localparam int HELD_W         = 5;
	localparam int TABLE_SIZE_DEF = 32;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = 21'h1FFFFF;

	localparam logic KIND_ENTRY = 1'b0;
	localparam logic KIND_CLOSE = 1'b1;

	// search token handed from cell to cell
	typedef struct packed {
		logic            vld;
		logic            hit;
		logic            app;
		logic [ID_W-1:0] id;
	} tok_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_CLOSE,
		ST_INJECT,
		ST_WAIT
	} state_t;

endpackage

`default_nettype wire

>>> rtl/pimrc_cell.sv
// ----------------------------------------------------------------------------
// pimrc_cell
// One table slot: a held id and its count. Passes the search token on each
// cycle, matching or appending on the way, and shifts its contents to the
// left neighbour during a summary rotation.
// ----------------------------------------------------------------------------
`default_nettype none

module pimrc_cell #(
	parameter int CW = 5
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               rot,
	input  pimrc_pkg::tok_t                   tok_in,
	input  wire [CW-1:0]                      rem_in,
	output pimrc_pkg::tok_t                   tok_out,
	output logic [CW-1:0]                     rem_out,
	input  wire [pimrc_pkg::ID_W-1:0]         nb_id,
	input  wire [pimrc_pkg::COUNT_W-1:0]      nb_count,
	output logic [pimrc_pkg::ID_W-1:0]        id_out,
	output logic [pimrc_pkg::COUNT_W-1:0]     count_out
);

	pimrc_pkg::tok_t                  tok_q;
	pimrc_pkg::tok_t                  tok_nx;
	logic [CW-1:0]                    rem_q;
	logic [CW-1:0]                    rem_nx;
	logic [pimrc_pkg::ID_W-1:0]       id_q;
	logic [pimrc_pkg::COUNT_W-1:0]    count_q;
	logic                             ld;
	logic                             inc;

	always_comb begin
		tok_nx = tok_in;
		rem_nx = rem_in;
		ld     = 1'b0;
		inc    = 1'b0;
		if (tok_in.vld && !tok_in.hit) begin
			if (rem_in == '0) begin
				// first free slot: append
				ld         = 1'b1;
				tok_nx.hit = 1'b1;
				tok_nx.app = 1'b1;
			end else begin
				rem_nx = rem_in - CW'(1);
				if (id_q == tok_in.id) begin
					inc        = 1'b1;
					tok_nx.hit = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nx;
		end
	end

	always_ff @(posedge clk) begin
		rem_q     <= rem_nx;
		if (rot) begin
			id_q    <= nb_id;
			count_q <= nb_count;
		end else if (ld) begin
			id_q    <= tok_in.id;
			count_q <= pimrc_pkg::COUNT_W'(1);
		end else if (inc && count_q != pimrc_pkg::COUNT_MAX) begin
			count_q <= count_q + pimrc_pkg::COUNT_W'(1);
		end
	end

	assign tok_out   = tok_q;
	assign rem_out   = rem_q;
	assign id_out    = id_q;
	assign count_out = count_q;

endmodule

`default_nettype wire

>>> rtl/per_id_message_rate_counter.sv
// ----------------------------------------------------------------------------
// per_id_message_rate_counter
// Counts received message ids per distinct id in a row of table cells and
// emits a summary run of per-id counts and a closing record on each
// second-boundary sync message.
// ----------------------------------------------------------------------------
//  channel  | signals                                    | handshake
//  ---------+--------------------------------------------+-----------------
//  input    | msg_id, tick_field                         | in_valid/in_stall
//  output   | record_kind, entry_id, entry_count,        | out_valid/out_stall
//           | total_count, ids_held, last                |
//  config   | sync_message_id                            | cfg_valid/cfg_ready
//
//  an item's search token walks the TABLE_SIZE-1 cells one per cycle
//  a summary rotates the table cell by cell and then loads a closing record;
//  a rotation that loads an entry, and the closing load, wait while out_stall
//  is high with a record held
//  one item at a time; in_stall is high from acceptance until the token exits
//  reset empties the table; no clearing pass is needed
// ----------------------------------------------------------------------------
`default_nettype none

module per_id_message_rate_counter #(
	parameter int TABLE_SIZE = pimrc_pkg::TABLE_SIZE_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	output logic                              in_stall,
	input  wire [pimrc_pkg::ID_W-1:0]         msg_id,
	input  wire [pimrc_pkg::TICK_W-1:0]       tick_field,
	output logic                              out_valid,
	input  wire                               out_stall,
	output logic                              record_kind,
	output logic [pimrc_pkg::ID_W-1:0]        entry_id,
	output logic [pimrc_pkg::COUNT_W-1:0]     entry_count,
	output logic [pimrc_pkg::TOTAL_W-1:0]     total_count,
	output logic [pimrc_pkg::HELD_W-1:0]      ids_held,
	output logic                              last,
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire [pimrc_pkg::ID_W-1:0]         sync_message_id
);

	localparam int CAP = TABLE_SIZE - 1;
	localparam int CW  = $clog2(TABLE_SIZE);
	localparam int HW  = (CW > pimrc_pkg::HELD_W) ? CW : pimrc_pkg::HELD_W;

	pimrc_pkg::state_t                state_q;
	pimrc_pkg::state_t                state_nx;

	pimrc_pkg::tok_t                  tok   [CAP+1];
	logic [CW-1:0]                    rem   [CAP+1];
	logic [pimrc_pkg::ID_W-1:0]       c_id  [CAP];
	logic [pimrc_pkg::COUNT_W-1:0]    c_cnt [CAP];

	logic [pimrc_pkg::ID_W-1:0]       sync_q;
	logic [pimrc_pkg::ID_W-1:0]       msg_q;
	logic [CW-1:0]                    entries_q;
	logic [CW-1:0]                    step_q;
	logic [pimrc_pkg::TOTAL_W-1:0]    total_q;
	logic [pimrc_pkg::TOTAL_W:0]      total_sum;
	logic [HW-1:0]                    held_ext;

	logic                             out_valid_q;
	logic                             kind_q;
	logic [pimrc_pkg::ID_W-1:0]       eid_q;
	logic [pimrc_pkg::COUNT_W-1:0]    ecnt_q;
	logic [pimrc_pkg::TOTAL_W-1:0]    tot_q;
	logic [pimrc_pkg::HELD_W-1:0]     held_q;
	logic                             last_q;

	logic                             in_xfer;
	logic                             can_load;
	logic                             emit;
	logic                             rot;
	logic                             ld_entry;
	logic                             ld_close;

	// cell row
	genvar g;
	generate
		for (g = 0; g < CAP; g++) begin : g_cell
			pimrc_cell #(
				.CW (CW)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.rot       (rot),
				.tok_in    (tok[g]),
				.rem_in    (rem[g]),
				.tok_out   (tok[g+1]),
				.rem_out   (rem[g+1]),
				.nb_id     ((g == CAP-1) ? c_id[0] : c_id[(g+1) % CAP]),
				.nb_count  ((g == CAP-1) ? '0 : c_cnt[(g+1) % CAP]),
				.id_out    (c_id[g]),
				.count_out (c_cnt[g])
			);
		end
	endgenerate

	// token injection
	always_comb begin
		tok[0].vld = (state_q == pimrc_pkg::ST_INJECT);
		tok[0].hit = (msg_q == '0);
		tok[0].app = 1'b0;
		tok[0].id  = msg_q;
		rem[0]     = entries_q;
	end

	assign in_xfer   = in_valid && !in_stall;
	assign can_load  = !out_valid_q || !out_stall;
	assign emit      = (step_q < entries_q);
	assign total_sum = {1'b0, total_q} + (pimrc_pkg::TOTAL_W+1)'(c_cnt[0]);
	assign held_ext  = HW'(entries_q);

	always_comb begin
		state_nx = state_q;
		rot      = 1'b0;
		ld_entry = 1'b0;
		ld_close = 1'b0;
		unique case (state_q)
			pimrc_pkg::ST_IDLE: begin
				if (in_xfer) begin
					if (msg_id == sync_q && tick_field == '0) begin
						state_nx = pimrc_pkg::ST_SUM;
					end else begin
						state_nx = pimrc_pkg::ST_INJECT;
					end
				end
			end
			pimrc_pkg::ST_SUM: begin
				if (!emit || can_load) begin
					rot      = 1'b1;
					ld_entry = emit;
					if (step_q == CW'(CAP-1)) begin
						state_nx = pimrc_pkg::ST_CLOSE;
					end
				end
			end
			pimrc_pkg::ST_CLOSE: begin
				if (can_load) begin
					ld_close = 1'b1;
					state_nx = pimrc_pkg::ST_INJECT;
				end
			end
			pimrc_pkg::ST_INJECT: begin
				state_nx = pimrc_pkg::ST_WAIT;
			end
			pimrc_pkg::ST_WAIT: begin
				if (tok[CAP].vld) begin
					state_nx = pimrc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = pimrc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pimrc_pkg::ST_IDLE;
			sync_q      <= '0;
			entries_q   <= '0;
			step_q      <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_valid && cfg_ready) begin
				sync_q <= sync_message_id;
			end
			if (state_q == pimrc_pkg::ST_IDLE) begin
				step_q  <= '0;
				total_q <= '0;
			end else if (rot) begin
				step_q <= step_q + CW'(1);
				if (ld_entry) begin
					total_q <= total_sum[pimrc_pkg::TOTAL_W] ?
						pimrc_pkg::TOTAL_MAX : total_sum[pimrc_pkg::TOTAL_W-1:0];
				end
			end
			if (state_q == pimrc_pkg::ST_WAIT && tok[CAP].vld && tok[CAP].app) begin
				entries_q <= entries_q + CW'(1);
			end
			if (ld_entry || ld_close) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// input id and output record registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			msg_q <= msg_id;
		end
		if (ld_entry) begin
			kind_q <= pimrc_pkg::KIND_ENTRY;
			eid_q  <= c_id[0];
			ecnt_q <= c_cnt[0];
			tot_q  <= '0;
			held_q <= '0;
			last_q <= 1'b0;
		end else if (ld_close) begin
			kind_q <= pimrc_pkg::KIND_CLOSE;
			eid_q  <= '0;
			ecnt_q <= '0;
			tot_q  <= total_q;
			held_q <= held_ext[pimrc_pkg::HELD_W-1:0];
			last_q <= 1'b1;
		end
	end

	assign in_stall    = (state_q != pimrc_pkg::ST_IDLE);
	assign cfg_ready   = (state_q == pimrc_pkg::ST_IDLE);
	assign out_valid   = out_valid_q;
	assign record_kind = kind_q;
	assign entry_id    = eid_q;
	assign entry_count = ecnt_q;
	assign total_count = tot_q;
	assign ids_held    = held_q;
	assign last        = last_q;

endmodule

`default_nettype wire

>>> rtl/pimrc_checker.sv
// ----------------------------------------------------------------------------
// pimrc_checker
// Port-level checks on the per-id message rate counter, bound to the top
// level.
// ----------------------------------------------------------------------------
`default_nettype none

module pimrc_checker (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	input  wire                               in_stall,
	input  wire                               out_valid,
	input  wire                               out_stall,
	input  wire                               record_kind,
	input  wire [pimrc_pkg::ID_W-1:0]         entry_id,
	input  wire [pimrc_pkg::COUNT_W-1:0]      entry_count,
	input  wire [pimrc_pkg::TOTAL_W-1:0]      total_count,
	input  wire [pimrc_pkg::HELD_W-1:0]       ids_held,
	input  wire                               last,
	input  wire                               cfg_ready
);

	// held record's id, count, total and last flag do not change
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(entry_id) &&
			$stable(entry_count) && $stable(total_count) && $stable(last))
		else $error("output record changed while stalled");

	// one item at a time
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after a transfer");

	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready == !in_stall)
		else $error("config ready while busy");

	a_close_rec: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> record_kind && entry_id == '0 && entry_count == '0)
		else $error("malformed closing record");

	a_entry_rec: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !record_kind |-> !last && total_count == '0 && ids_held == '0)
		else $error("malformed entry record");

endmodule

bind per_id_message_rate_counter pimrc_checker u_pimrc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.record_kind (record_kind),
	.entry_id    (entry_id),
	.entry_count (entry_count),
	.total_count (total_count),
	.ids_held    (ids_held),
	.last        (last),
	.cfg_ready   (cfg_ready)
);

`default_nettype wire
